[design/spq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// shared opcodes and controller/datapath interface types of the sorted
// priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned OP_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_PEEK   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

  // command from the controller to the datapath
  typedef struct packed {
    logic load;    // capture a new result this cycle
    logic insert;  // place the new entry in order
    logic remove;  // drop the head entry
    logic error;   // request hit a full or an empty queue
  } spq_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
  } spq_status_t;

endpackage : spq_pkg
`default_nettype wire

[design/sorted_priority_queue_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// sorted-array priority queue: insert in priority order, remove the head,
// report head entry, count and error after every request
// ----------------------------------------------------------------------------
// timing: the result of an accepted request is valid in the cycle after its acceptance
// throughput: one request per cycle, set by the parallel compare-and-shift
//   across the entry cells; a stalled result holds the input off
// reset: entry count and the result valid flag clear; entry cells are not
//   reset and are only read below the count
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PRIO_BITS = 16,
  parameter int unsigned DATA_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [OP_BITS-1:0]            opcode_i,
  input  wire logic [PRIO_BITS-1:0]          priority_req_i,
  input  wire logic [DATA_BITS-1:0]          payload_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               head_valid_o,
  output logic [PRIO_BITS-1:0]               head_priority_o,
  output logic [DATA_BITS-1:0]               head_payload_o,
  output logic [$clog2(DEPTH + 1)-1:0]       count_o,
  output logic                               error_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  spq_cmd_t    cmd;
  spq_status_t status;

  // controller: handshake, opcode decode, full/empty checks
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: entry cells kept in ascending order, and the result register
  spq_datapath #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .DATA_BITS (DATA_BITS),
    .CNT_W     (CNT_W)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .priority_req_i  (priority_req_i),
    .payload_i       (payload_i),
    .head_valid_o    (head_valid_o),
    .head_priority_o (head_priority_o),
    .head_payload_o  (head_payload_o),
    .count_o         (count_o),
    .error_o         (error_o)
  );

  // an accepted request always leaves a result behind
  a_accept_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  // the queue never reports more entries than it can hold
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CNT_W'(DEPTH)))
    else $error("count beyond queue depth");

  // head valid agrees with the count
  a_head_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_valid_o == (count_o != '0)))
    else $error("head valid disagrees with count");

  // insert and remove are never issued together, nor with an error
  a_cmd_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.insert, cmd.remove, cmd.error}))
    else $error("conflicting datapath commands");

endmodule : sorted_priority_queue_unit
`default_nettype wire

[design/spq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// handshake controller: accepts requests, decodes opcodes and holds the
// result until the consumer takes it
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [OP_BITS-1:0] opcode_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire spq_status_t        status_i,
  output spq_cmd_t                cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_stall_o  = (state_q == ST_HOLD) && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_HOLD);

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept;
    if (accept) begin
      case (opcode_i)
        OP_INSERT: begin
          cmd_o.insert = !status_i.full;
          cmd_o.error  = status_i.full;
        end
        OP_REMOVE: begin
          cmd_o.remove = !status_i.empty;
          cmd_o.error  = status_i.empty;
        end
        default: begin
          // peek and the unused code change nothing
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = ST_HOLD;
    end else if (!out_stall_i) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : spq_ctrl
`default_nettype wire

[design/spq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// row of sorted entry cells with parallel compare-and-shift, plus the
// result register
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PRIO_BITS = 16,
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire spq_cmd_t             cmd_i,
  output spq_status_t               status_o,
  input  wire logic [PRIO_BITS-1:0] priority_req_i,
  input  wire logic [DATA_BITS-1:0] payload_i,
  output logic                      head_valid_o,
  output logic [PRIO_BITS-1:0]      head_priority_o,
  output logic [DATA_BITS-1:0]      head_payload_o,
  output logic [CNT_W-1:0]          count_o,
  output logic                      error_o
);

  logic [PRIO_BITS-1:0] prio_q [DEPTH];
  logic [PRIO_BITS-1:0] prio_d [DEPTH];
  logic [DATA_BITS-1:0] data_q [DEPTH];
  logic [DATA_BITS-1:0] data_d [DEPTH];
  logic [CNT_W-1:0]     count_q, count_d;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (cmd_i.remove) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic below_ok;   // entry below goes before the new one (or none below)
    logic here_after; // this entry goes after the new one (or slot unused)
    logic pull_up;    // next entry exists and moves down on remove

    if (i == 0) begin : g_first
      assign below_ok = 1'b1;
    end else begin : g_rest
      assign below_ok = (prio_q[i-1] <= priority_req_i);
    end

    assign here_after = (CNT_W'(i) >= count_q) || (prio_q[i] > priority_req_i);

    if (i == DEPTH - 1) begin : g_top
      assign pull_up = 1'b0;
    end else begin : g_mid
      assign pull_up = (CNT_W'(i + 1) < count_q);
    end

    always_comb begin
      prio_d[i] = prio_q[i];
      data_d[i] = data_q[i];
      if (cmd_i.insert && (CNT_W'(i) <= count_q)) begin
        if (below_ok && here_after) begin
          prio_d[i] = priority_req_i;
          data_d[i] = payload_i;
        end else if (!below_ok) begin
          prio_d[i] = prio_q[(i == 0) ? 0 : i - 1];
          data_d[i] = data_q[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd_i.remove && pull_up) begin
        prio_d[i] = prio_q[(i == DEPTH - 1) ? i : i + 1];
        data_d[i] = data_q[(i == DEPTH - 1) ? i : i + 1];
      end
    end

    always_ff @(posedge clk_i) begin
      prio_q[i] <= prio_d[i];
      data_q[i] <= data_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result register, zero head fields when empty
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      head_valid_o    <= (count_d != '0);
      head_priority_o <= (count_d != '0) ? prio_d[0] : '0;
      head_payload_o  <= (count_d != '0) ? data_d[0] : '0;
      count_o         <= count_d;
      error_o         <= cmd_i.error;
    end
  end

endmodule : spq_datapath
`default_nettype wire
